>>> hw/rtl/utf16le_to_utf8_transcoder_assert.svh
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder assertion macros
// Shared concurrent assertion forms used by the transcoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF16LE_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define U16U8_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define U16U8_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and UTF-8 encoding helpers for the UTF-16LE transcoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam int UnitW   = 16;
  localparam int CpW     = 21;
  localparam int HeldW   = 10;
  localparam int ByteW   = 8;
  localparam int JobQDepth = 2;

  // surrogate tags in the top six bits of a code unit
  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;

  localparam logic [CpW-1:0] SuppBase = 21'h10000;

  // one encode job: optional flushed high surrogate, then optional code point
  typedef struct packed {
    logic              flush_vld;
    logic [HeldW-1:0]  flush_held;
    logic              main_vld;
    logic [CpW-1:0]    main_cp;
  } job_t;

  // index of the final byte of the utf-8 form of cp
  function automatic logic [1:0] enc_last_idx(input logic [CpW-1:0] cp);
    logic [1:0] r;
    if (cp < 21'h80) begin
      r = 2'd0;
    end else if (cp < 21'h800) begin
      r = 2'd1;
    end else if (cp < 21'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // byte idx of the utf-8 form of cp, whose final byte index is last
  function automatic logic [ByteW-1:0] enc_byte(input logic [CpW-1:0] cp,
                                                input logic [1:0]     last,
                                                input logic [1:0]     idx);
    logic [ByteW-1:0] b;
    logic [1:0]       rem;
    rem = last - idx;
    b   = '0;
    if (idx == 2'd0) begin
      case (last)
        2'd0:    b = {1'b0, cp[6:0]};
        2'd1:    b = {3'b110, cp[10:6]};
        2'd2:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

>>> hw/rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and issues encode jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u16u8_front import u16u8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [UnitW-1:0] code_unit_i,
  input  logic             stream_end_i,
  output logic             job_vld_o,
  input  logic             job_rdy_i,
  output job_t             job_o
);

  logic             pend_vld_q, pend_vld_d;
  logic [HeldW-1:0] pend_held_q, pend_held_d;
  logic             is_high, is_low, accept, hold_new;

  // classify the incoming unit
  assign is_high  = (code_unit_i[15:10] == HighTag);
  assign is_low   = (code_unit_i[15:10] == LowTag);
  assign hold_new = is_high && !stream_end_i;
  assign full     = !job_rdy_i;
  assign accept   = push && !full;

  // build the job and the next held surrogate
  always_comb begin
    job_o       = '0;
    pend_vld_d  = pend_vld_q;
    pend_held_d = pend_held_q;
    if (pend_vld_q && is_low) begin
      job_o.main_vld = 1'b1;
      job_o.main_cp  = {1'b0, pend_held_q, code_unit_i[9:0]} + SuppBase;
    end else begin
      job_o.flush_vld  = pend_vld_q;
      job_o.flush_held = pend_held_q;
      job_o.main_vld   = !hold_new;
      job_o.main_cp    = {{(CpW-UnitW){1'b0}}, code_unit_i};
    end
    if (accept) begin
      pend_vld_d  = hold_new && !(pend_vld_q && is_low);
      pend_held_d = code_unit_i[9:0];
    end
  end

  assign job_vld_o = accept && (job_o.flush_vld || job_o.main_vld);

  // held surrogate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q  <= 1'b0;
      pend_held_q <= '0;
    end else begin
      pend_vld_q  <= pend_vld_d;
      pend_held_q <= pend_held_d;
    end
  end

endmodule

>>> hw/rtl/u16u8_jobq.sv
// ----------------------------------------------------------------------------
// u16u8_jobq
// Two-entry job queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u16u8_jobq import u16u8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_vld_i,
  output logic wr_rdy_o,
  input  job_t wr_job_i,
  output logic rd_vld_o,
  input  logic rd_pop_i,
  output job_t rd_job_o
);

  localparam int PtrW = $clog2(JobQDepth);
  localparam int CntW = $clog2(JobQDepth + 1);

  job_t            mem_q [JobQDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign wr_rdy_o = (cnt_q != CntW'(JobQDepth));
  assign rd_vld_o = (cnt_q != '0);
  assign do_wr    = wr_vld_i && wr_rdy_o;
  assign do_rd    = rd_pop_i && rd_vld_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(JobQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(JobQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Walks each job byte by byte and holds the oldest beat in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u16u8_back import u16u8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_vld_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [ByteW-1:0] out_byte_o,
  output logic             run_last_o
);

  logic             flush_done_q;
  logic [1:0]       idx_q;
  logic             out_vld_q;
  logic [ByteW-1:0] out_byte_q;
  logic             run_last_q;

  logic             sel_main, cp_last, job_last, advance;
  logic [CpW-1:0]   cp;
  logic [1:0]       last_idx;
  logic [ByteW-1:0] cur_byte;

  // pick the code point being emitted
  assign sel_main = !job_i.flush_vld || flush_done_q;
  assign cp       = sel_main ? job_i.main_cp
                             : {{(CpW-UnitW){1'b0}}, HighTag, job_i.flush_held};
  assign last_idx = enc_last_idx(cp);
  assign cur_byte = enc_byte(cp, last_idx, idx_q);
  assign cp_last  = (idx_q == last_idx);
  assign job_last = cp_last && (sel_main || !job_i.main_vld);

  // move a byte when the output register is free or being drained
  assign advance   = job_vld_i && (!out_vld_q || pop);
  assign job_pop_o = advance && job_last;

  // sequencer position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_done_q <= 1'b0;
      idx_q        <= '0;
    end else if (advance) begin
      if (cp_last) begin
        idx_q        <= '0;
        flush_done_q <= !job_last;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= cur_byte;
      run_last_q <= job_last;
    end
  end

  assign empty      = !out_vld_q;
  assign out_byte_o = out_byte_q;
  assign run_last_o = run_last_q;

endmodule

>>> hw/rtl/utf16le_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// UTF-16LE code units in, UTF-8 bytes out, with surrogate pairing.
// ----------------------------------------------------------------------------
// The output side delivers one byte per cycle while the consumer pops and a
// job is queued. An ordinary code unit produces one to three bytes, a
// surrogate pair four, and a held high surrogate flushed ahead of the new
// unit adds three more, up to six in all; a high surrogate that is held
// produces nothing. The byte sequencer in the back end emits these bytes.
// Input units are taken back to back as long as the two-entry job queue has
// room, and a finished byte waiting on the output does not stop the front.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder import u16u8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [UnitW-1:0] code_unit_i,
  input  logic             stream_end_i,
  output logic             empty,
  input  logic             pop,
  output logic [ByteW-1:0] out_byte_o,
  output logic             run_last_o
);

  logic job_wr_vld, job_wr_rdy, job_rd_vld, job_rd_pop;
  job_t job_wr, job_rd;

  // front end: surrogate pairing
  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_unit_i  (code_unit_i),
    .stream_end_i (stream_end_i),
    .job_vld_o    (job_wr_vld),
    .job_rdy_i    (job_wr_rdy),
    .job_o        (job_wr)
  );

  // job queue
  u16u8_jobq u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_vld_i (job_wr_vld),
    .wr_rdy_o (job_wr_rdy),
    .wr_job_i (job_wr),
    .rd_vld_o (job_rd_vld),
    .rd_pop_i (job_rd_pop),
    .rd_job_o (job_rd)
  );

  // back end: byte sequencer and output register
  u16u8_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_vld_i  (job_rd_vld),
    .job_i      (job_rd),
    .job_pop_o  (job_rd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o)
  );

endmodule

>>> hw/rtl/u16u8_props.sv
// ----------------------------------------------------------------------------
// u16u8_props
// Port-level checks for the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf16le_to_utf8_transcoder_assert.svh"

module u16u8_props import u16u8_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic [UnitW-1:0] code_unit_i,
  input logic             stream_end_i,
  input logic             empty,
  input logic             pop,
  input logic [ByteW-1:0] out_byte_o,
  input logic             run_last_o
);

  // a waiting beat stays until taken
  `U16U8_ASSERT_NXT(a_beat_holds, clk_i, rst_ni, !empty && !pop, !empty, "beat dropped")
  // its payload does not change while stalled
  `U16U8_ASSERT_NXT(a_byte_holds, clk_i, rst_ni, !empty && !pop, $stable(out_byte_o), "beat changed")
  // a lead byte of a multi-byte sequence never ends a run
  `U16U8_ASSERT_NOW(a_lead_not_last, clk_i, rst_ni, !empty && out_byte_o[7:6] == 2'b11, !run_last_o, "lead byte marked last")
  // an ascii byte always ends its run
  `U16U8_ASSERT_NOW(a_ascii_last, clk_i, rst_ni, !empty && !out_byte_o[7], run_last_o, "ascii byte not last")
  // no byte beyond a four-byte lead
  `U16U8_ASSERT_NOW(a_no_bad_lead, clk_i, rst_ni, !empty, out_byte_o[7:3] != 5'b11111, "illegal lead byte")

endmodule

bind utf16le_to_utf8_transcoder u16u8_props u_props (.*);

>>> test/tb_utf16le_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// tb_utf16le_to_utf8_transcoder
// Drives UTF-16 code units through the push side and checks every UTF-8 byte
// popped against a local transcoder model. A table of directed units covers
// the code point range edges and every surrogate case; random units follow,
// mostly well-formed pairs and ordinary text with lone surrogates mixed in.
// Both sides stall at random, with calm stretches between the stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf16le_to_utf8_transcoder;
  import u16u8_pkg::*;

  localparam int ClkPeriod = 8;
  localparam int DirRows   = 25;
  localparam int RandUnits = 355;
  localparam int CycLimit  = 300000;
  localparam int DrainMax  = 20000;
  localparam int TailWait  = 30;

  // one code unit to send; typed rows carry their byte string, first byte on top
  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             fin;
    logic             typed;
    logic [2:0]       n_bytes;
    logic [47:0]      bytes;
  } unit_row_t;

  // one expected output beat
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } utf8_beat_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             push         = 1'b0;
  logic [UnitW-1:0] code_unit_i  = '0;
  logic             stream_end_i = 1'b0;
  logic             pop          = 1'b0;
  logic             full;
  logic             empty;
  logic [ByteW-1:0] out_byte_o;
  logic             run_last_o;

  utf8_beat_t       utf8_q[$];     // bytes still owed by the block, oldest first
  unit_row_t        sent_rows[$];  // unit currently offered on the push side
  logic [ByteW-1:0] enc_bytes[$];  // bytes produced by the current unit
  unit_row_t        dir_tab [DirRows];

  // model state: held high surrogate
  logic [9:0] held_bits = '0;
  logic       held_vld  = 1'b0;

  int  err_cnt   = 0;
  int  unit_cnt  = 0;
  int  byte_cnt  = 0;
  int  pair_cnt  = 0;
  int  flush_cnt = 0;
  int  cyc       = 0;
  logic src_calm = 1'b0;
  logic snk_calm = 1'b0;

  utf16le_to_utf8_transcoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_unit_i  (code_unit_i),
    .stream_end_i (stream_end_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o)
  );

  // clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // append one byte to the current unit's byte string
  function automatic void add_enc(input logic [ByteW-1:0] b);
    enc_bytes.insert(enc_bytes.size(), b);
  endfunction

  // utf-8 form of one code point
  function automatic void encode_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_enc(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_enc({3'b110, cp[10:6]});
      add_enc({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_enc({4'b1110, cp[15:12]});
      add_enc({2'b10, cp[11:6]});
      add_enc({2'b10, cp[5:0]});
    end else begin
      add_enc({5'b11110, cp[20:18]});
      add_enc({2'b10, cp[17:12]});
      add_enc({2'b10, cp[11:6]});
      add_enc({2'b10, cp[5:0]});
    end
  endfunction

  // bytes caused by one accepted unit, with surrogate pairing and flushing
  function automatic void transcode_unit(input logic [UnitW-1:0] unit, input logic fin);
    logic is_high;
    logic is_low;
    is_high = (unit >= 16'hD800) && (unit < 16'hDC00);
    is_low  = (unit >= 16'hDC00) && (unit < 16'hE000);
    enc_bytes.delete();
    if (held_vld) begin
      held_vld = 1'b0;
      if (is_low) begin
        encode_cp(21'h10000 + {held_bits, unit[9:0]});
        held_bits = '0;
        pair_cnt++;
        return;
      end
      // held surrogate goes out alone ahead of the new unit
      encode_cp({5'b0, 6'b110110, held_bits});
      held_bits = '0;
      flush_cnt++;
    end
    if (is_high && !fin) begin
      held_bits = unit[9:0];
      held_vld  = 1'b1;
    end else begin
      encode_cp({5'b0, unit});
    end
  endfunction

  function automatic void note_error(input string msg);
    if (err_cnt < 10) $display("mismatch: %s", msg);
    err_cnt++;
  endfunction

  // offer one unit after a random gap and hold it until the block takes it
  task automatic send_unit(input unit_row_t row);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    sent_rows.insert(sent_rows.size(), row);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    code_unit_i  <= row.unit;
    stream_end_i <= row.fin;
    do @(posedge clk_i); while (full);
  endtask

  // accepted units feed the model, popped beats are checked
  always @(posedge clk_i) begin
    unit_row_t  row;
    utf8_beat_t want;
    utf8_beat_t beat;
    if (rst_ni && push && !full) begin
      row = sent_rows.pop_front();
      transcode_unit(code_unit_i, stream_end_i);
      unit_cnt++;
      if (row.typed) begin
        enc_bytes.delete();
        for (int i = 0; i < row.n_bytes; i++) add_enc(row.bytes[47-8*i -: 8]);
      end
      foreach (enc_bytes[i]) begin
        beat.data = enc_bytes[i];
        beat.last = (i == enc_bytes.size() - 1);
        utf8_q.insert(utf8_q.size(), beat);
      end
    end
    if (rst_ni && pop && !empty) begin
      byte_cnt++;
      if (utf8_q.size() == 0) begin
        note_error($sformatf("unexpected byte %02h last %0b", out_byte_o, run_last_o));
      end else begin
        want = utf8_q.pop_front();
        if (out_byte_o !== want.data || run_last_o !== want.last) begin
          note_error($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                               byte_cnt, want.data, want.last, out_byte_o, run_last_o));
        end
      end
    end
  end

  // pop side with random stalls and calm stretches
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_calm = ~snk_calm;
      gap = snk_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // watchdog
  initial begin
    while (cyc < CycLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("run stopped after %0d cycles with %0d bytes outstanding", cyc, utf8_q.size());
    $display("FAIL utf16le_to_utf8_transcoder");
    $finish;
  end

  // stimulus and verdict
  initial begin
    unit_row_t        row;
    logic [UnitW-1:0] u;
    logic             fin;
    int               kind;
    int               sent;
    int               drain;

    // directed units: range edges, pairing, lone surrogates, flush at end
    dir_tab[0]  = '{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_0000000000};
    dir_tab[1]  = '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_0000000000};
    dir_tab[2]  = '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC280_00000000};
    dir_tab[3]  = '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDFBF_00000000};
    dir_tab[4]  = '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0A080_000000};
    dir_tab[5]  = '{16'hFFFF, 1'b0, 1'b1, 3'd3, 48'hEFBFBF_000000};
    dir_tab[6]  = '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0};
    dir_tab[7]  = '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0908080_0000};
    dir_tab[8]  = '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0};
    dir_tab[9]  = '{16'hDFFF, 1'b0, 1'b1, 3'd4, 48'hF48FBFBF_0000};
    dir_tab[10] = '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hEDB080_000000};
    dir_tab[11] = '{16'hD800, 1'b1, 1'b1, 3'd3, 48'hEDA080_000000};
    dir_tab[12] = '{16'hD83D, 1'b0, 1'b1, 3'd0, 48'h0};
    dir_tab[13] = '{16'hD83D, 1'b1, 1'b0, 3'd0, 48'h0};
    dir_tab[14] = '{16'hDABC, 1'b0, 1'b1, 3'd0, 48'h0};
    dir_tab[15] = '{16'h0041, 1'b0, 1'b0, 3'd0, 48'h0};
    dir_tab[16] = '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0};
    dir_tab[17] = '{16'h07FF, 1'b0, 1'b0, 3'd0, 48'h0};
    dir_tab[18] = '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0};
    dir_tab[19] = '{16'hFFFF, 1'b0, 1'b0, 3'd0, 48'h0};
    dir_tab[20] = '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0};
    dir_tab[21] = '{16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h0};
    dir_tab[22] = '{16'hDFFF, 1'b1, 1'b0, 3'd0, 48'h0};
    dir_tab[23] = '{16'hAAAA, 1'b1, 1'b0, 3'd0, 48'h0};
    dir_tab[24] = '{16'h5555, 1'b0, 1'b0, 3'd0, 48'h0};

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_unit(dir_tab[i]);

    // random text: mostly clean units and pairs, some lone surrogates and noise
    sent = 0;
    while (sent < RandUnits) begin
      if ($urandom_range(0, 47) == 0) src_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      fin  = ($urandom_range(0, 15) == 0);
      case (kind) inside
        0: u = UnitW'($urandom_range(0, 16'h7F));
        1: u = UnitW'($urandom_range(16'h80, 16'h7FF));
        2: u = $urandom_range(0, 1) ? UnitW'($urandom_range(16'h800, 16'hD7FF))
                                    : UnitW'($urandom_range(16'hE000, 16'hFFFF));
        [3:5]: begin
          row = '{UnitW'($urandom_range(16'hD800, 16'hDBFF)), ($urandom_range(0, 31) == 0),
                  1'b0, 3'd0, 48'h0};
          send_unit(row);
          sent++;
          u = UnitW'($urandom_range(16'hDC00, 16'hDFFF));
        end
        6: begin
          row = '{UnitW'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, 1'b0, 3'd0, 48'h0};
          send_unit(row);
          sent++;
          u = $urandom_range(0, 1) ? UnitW'($urandom_range(16'hD800, 16'hDBFF))
                                   : UnitW'($urandom_range(0, 16'hD7FF));
        end
        7: u = UnitW'($urandom_range(16'hDC00, 16'hDFFF));
        default: u = UnitW'($urandom());
      endcase
      row = '{u, fin, 1'b0, 3'd0, 48'h0};
      send_unit(row);
      sent++;
    end

    // close the stream so nothing stays held
    row = '{UnitW'($urandom_range(0, 16'h7F)), 1'b1, 1'b0, 3'd0, 48'h0};
    send_unit(row);
    push <= 1'b0;

    // drain, then give stray bytes a chance to show up
    drain = 0;
    while (utf8_q.size() != 0 && drain < DrainMax) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TailWait) @(posedge clk_i);
    if (utf8_q.size() != 0) note_error($sformatf("%0d bytes never came out", utf8_q.size()));

    $display("covered %0d code units: %0d surrogate pairs, %0d flushed high surrogates",
             unit_cnt, pair_cnt, flush_cnt);
    $display("checked %0d utf-8 bytes under random stalls on both sides", byte_cnt);
    if (err_cnt == 0) begin
      $display("PASS utf16le_to_utf8_transcoder");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("FAIL utf16le_to_utf8_transcoder");
    end
    $finish;
  end

endmodule
